[hw/rtl/ghash_pkg.sv]
// Shared types and constants for the GHASH accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ghash_pkg;

    // Width of one GF(2^128) element and of each packed half.
    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_HASH_KEY_HIGH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_KEY_LOW     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE_HIGH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE_LOW  = 2'd3;

    // Reduction polynomial x^128 + x^7 + x^2 + x + 1 in GCM bit order
    // (coefficient x^0 at the most significant bit).
    localparam logic [BLOCK_W-1:0] GCM_R = {8'hE1, 120'd0};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new block and start a multiply
        logic step;    // process one digit of the multiplier
        logic commit;  // this step is the last one: update the accumulator
        logic emit;    // also load the digest output register
    } ghash_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/ghash_in_if.sv]
// Input channel of the GHASH accumulator: one data block per beat.
// Valid/ready handshake; depends on nothing.
`default_nettype none

interface ghash_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        last_block;

    modport source (output valid, output block_high, output block_low,
                    output first_block, output last_block, input ready);
    modport sink   (input valid, input block_high, input block_low,
                    input first_block, input last_block, output ready);
endinterface

`default_nettype wire

[hw/rtl/ghash_out_if.sv]
// Output channel of the GHASH accumulator: one digest per beat.
// Valid/ready handshake; depends on nothing.
`default_nettype none

interface ghash_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_high;
    logic [63:0] digest_low;

    modport source (output valid, output digest_high, output digest_low, input ready);
    modport sink   (input valid, input digest_high, input digest_low, output ready);
endinterface

`default_nettype wire

[hw/rtl/ghash_datapath.sv]
// Datapath of the GHASH accumulator: configuration registers, the digit-serial
// GF(2^128) multiplier, the accumulator and the digest register. Uses ghash_pkg.
`default_nettype none

module ghash_datapath
    import ghash_pkg::*;
#(
    parameter int DIGIT_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ghash_cmd_t             cmd,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [HALF_W-1:0]      block_high,
    input  wire logic [HALF_W-1:0]      block_low,
    input  wire logic                   first_block,
    output logic      [HALF_W-1:0]      digest_high,
    output logic      [HALF_W-1:0]      digest_low
);

    logic [HALF_W-1:0]  key_high_reg, key_low_reg;
    logic [HALF_W-1:0]  start_high_reg, start_low_reg;
    logic [BLOCK_W-1:0] acc_reg;
    logic [BLOCK_W-1:0] x_reg, x_next;
    logic [BLOCK_W-1:0] v_reg, v_next;
    logic [BLOCK_W-1:0] z_reg, z_next;
    logic [BLOCK_W-1:0] digest_reg;
    logic [BLOCK_W-1:0] chain_value;
    logic [BLOCK_W-1:0] y_start;

    // Configuration registers; the user must write only while idle (unenforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            start_high_reg <= '0;
            start_low_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HASH_KEY_HIGH:    key_high_reg   <= cfg_data;
                REG_HASH_KEY_LOW:     key_low_reg    <= cfg_data;
                REG_START_VALUE_HIGH: start_high_reg <= cfg_data;
                REG_START_VALUE_LOW:  start_low_reg  <= cfg_data;
            endcase
        end
    end

    // One digit of the shift-and-add multiply: for each multiplier bit, most
    // significant first, add V when the bit is set, then multiply V by x.
    always_comb
    begin
        z_next = z_reg;
        v_next = v_reg;
        for (int k = 0; k < DIGIT_BITS; k++)
        begin
            if (x_reg[BLOCK_W-1-k])
            begin
                z_next = z_next ^ v_next;
            end
            v_next = {1'b0, v_next[BLOCK_W-1:1]} ^ (v_next[0] ? GCM_R : '0);
        end
        x_next = x_reg << DIGIT_BITS;
    end

    // A block loaded in the same cycle as the previous product completes
    // chains from that product directly.
    assign chain_value = cmd.commit ? z_next : acc_reg;
    assign y_start     = first_block ? {start_high_reg, start_low_reg} : chain_value;

    // Multiplier operand registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= y_start ^ {block_high, block_low};
            v_reg <= {key_high_reg, key_low_reg};
            z_reg <= '0;
        end
        else if (cmd.step)
        begin
            x_reg <= x_next;
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

    // Accumulator, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.commit)
        begin
            acc_reg <= z_next;
        end
    end

    // Digest output register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            digest_reg <= z_next;
        end
    end

    assign digest_high = digest_reg[BLOCK_W-1:HALF_W];
    assign digest_low  = digest_reg[HALF_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/ghash_controller.sv]
// Controller of the GHASH accumulator: sequences the digit steps of each
// multiply and owns both handshakes. Uses ghash_pkg.
`default_nettype none

module ghash_controller
    import ghash_pkg::*;
#(
    parameter int DIGIT_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output ghash_cmd_t      cmd
);

    localparam int NUM_STEPS = (BLOCK_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int STEP_W    = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_COUNT = STEP_W'(NUM_STEPS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] count_reg;
    logic              last_reg;
    logic              out_valid_reg;
    logic              final_step;
    logic              stall;
    logic              commit;
    logic              load;

    // A last result cannot complete while the previous digest is unread.
    assign final_step = (state_reg == ST_RUN) && (count_reg == LAST_COUNT);
    assign stall      = last_reg && out_valid_reg && !out_ready;
    assign commit     = final_step && !stall;
    assign in_ready   = (state_reg == ST_IDLE) || commit;
    assign load       = in_valid && in_ready;

    assign cmd.load   = load;
    assign cmd.step   = (state_reg == ST_RUN) && !(final_step && stall);
    assign cmd.commit = commit;
    assign cmd.emit   = commit && last_reg;
    assign out_valid  = out_valid_reg;

    // State, step counter, pending last flag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                state_reg <= ST_RUN;
                count_reg <= '0;
                last_reg  <= in_last;
            end
            else if (commit)
            begin
                state_reg <= ST_IDLE;
            end
            else if (state_reg == ST_RUN && !final_step)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (commit && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ghash_accumulator_unit.sv]
// GHASH accumulator, the top level: controller and datapath joined by commands.
// Uses ghash_pkg, ghash_in_if, ghash_out_if, ghash_controller, ghash_datapath.
`default_nettype none

// Each block beat updates Y = (Y xor block) * H in GF(2^128) with GCM bit
// order; a beat with first_block set starts from the start value register, and
// a beat with last_block set delivers the updated Y as one digest beat. The
// multiply is digit serial, DIGIT_BITS multiplier bits per cycle unless
// stalled. A block accepted from idle is registered before its multiply
// starts; a block offered while the previous multiply finishes is taken in
// its final cycle, so a steady stream keeps the multiplier busy without a
// gap. The digest sits in an output register, and only a finishing last block
// waits on an unread digest. Configuration registers are to be written only
// while the block is idle; the block itself does not enforce this.

module ghash_accumulator_unit
    import ghash_pkg::*;
#(
    parameter int DIGIT_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    ghash_in_if.sink                    blocks,
    ghash_out_if.source                 digests,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    ghash_cmd_t cmd;
    logic       in_ready;
    logic       out_valid;

    // Sequencing and handshakes.
    ghash_controller #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (blocks.valid),
        .in_ready  (in_ready),
        .in_last   (blocks.last_block),
        .out_valid (out_valid),
        .out_ready (digests.ready),
        .cmd       (cmd)
    );

    // Registers, multiplier and accumulator.
    ghash_datapath #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .block_high  (blocks.block_high),
        .block_low   (blocks.block_low),
        .first_block (blocks.first_block),
        .digest_high (digests.digest_high),
        .digest_low  (digests.digest_low)
    );

    assign blocks.ready  = in_ready;
    assign digests.valid = out_valid;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for ghash_accumulator_unit: GHASH chains over GF(2^128).
// Uses ghash_pkg, ghash_in_if and ghash_out_if; predicts every digest with a
// local bit-serial multiply and checks each digest beat against it.
`timescale 1ns / 1ps

module tb;
    import ghash_pkg::*;

    // Reduction term in GCM bit order and the field element one (x^0 at the MSB).
    localparam logic [127:0] REDUCTION   = {8'hE1, 120'd0};
    localparam logic [127:0] FIELD_ONE   = {1'b1, 127'd0};
    localparam logic [127:0] ALL_ONES    = {128{1'b1}};
    localparam int           DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } digest_t;

    logic clk;
    logic rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ghash_in_if  blocks_if ();
    ghash_out_if digests_if ();

    ghash_accumulator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .blocks    (blocks_if),
        .digests   (digests_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: register copies and the running hash value.
    logic [127:0] hash_key;
    logic [127:0] start_value;
    logic [127:0] running_y;
    digest_t      pending_digests[$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Product of two field elements, one multiplier bit per step.
    function automatic logic [127:0] gf128_product(input logic [127:0] x,
                                                   input logic [127:0] h);
        logic [127:0] acc;
        logic [127:0] v;
        acc = '0;
        v   = h;
        for (int i = 0; i < 128; i++)
        begin
            if (x[127 - i])
                acc ^= v;
            v = v[0] ? ((v >> 1) ^ REDUCTION) : (v >> 1);
        end
        return acc;
    endfunction

    // Random 64-bit value biased toward the extremes.
    function automatic logic [63:0] rand64();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return {64{1'b1}};
            2: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Receiver: ready is redrawn every cycle from the stall percentage.
    always @(posedge clk)
    begin
        digests_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each digest beat is compared with the oldest expected digest.
    always @(posedge clk)
    begin : check_digests
        digest_t want;
        if (rst_n && digests_if.valid && digests_if.ready)
        begin
            if (pending_digests.size() == 0)
            begin
                $error("digest beat with none expected: %h %h",
                       digests_if.digest_high, digests_if.digest_low);
                fail_count++;
            end
            else
            begin
                want = pending_digests.pop_front();
                if (digests_if.digest_high !== want.high)
                begin
                    $error("digest_high expected %h actual %h", want.high,
                           digests_if.digest_high);
                    fail_count++;
                end
                if (digests_if.digest_low !== want.low)
                begin
                    $error("digest_low expected %h actual %h", want.low,
                           digests_if.digest_low);
                    fail_count++;
                end
            end
        end
    end

    // Updates the running hash for one accepted block beat.
    task automatic hash_block(input logic [127:0] data, input logic first, input logic last);
        running_y = gf128_product((first ? start_value : running_y) ^ data, hash_key);
        if (last)
            pending_digests.push_back(running_y);
    endtask

    // Sends one block beat after a random gap and waits for it to be taken.
    task automatic send_block(input logic [63:0] bh, input logic [63:0] bl,
                              input logic first, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            blocks_if.valid <= 1'b0;
            @(posedge clk);
        end
        blocks_if.valid       <= 1'b1;
        blocks_if.block_high  <= bh;
        blocks_if.block_low   <= bl;
        blocks_if.first_block <= first;
        blocks_if.last_block  <= last;
        do
            @(posedge clk);
        while (!blocks_if.ready);
        hash_block({bh, bl}, first, last);
    endtask

    // Lets every expected digest arrive and the last multiply finish.
    task automatic wait_idle();
        blocks_if.valid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_HASH_KEY_HIGH:    hash_key[127:64]    = data;
            REG_HASH_KEY_LOW:     hash_key[63:0]      = data;
            REG_START_VALUE_HIGH: start_value[127:64] = data;
            REG_START_VALUE_LOW:  start_value[63:0]   = data;
            default: ;
        endcase
    endtask

    // Writes the hash key and the start value; the block must be idle.
    task automatic load_settings(input logic [127:0] key, input logic [127:0] y0);
        write_reg(REG_HASH_KEY_HIGH, key[127:64]);
        write_reg(REG_HASH_KEY_LOW, key[63:0]);
        write_reg(REG_START_VALUE_HIGH, y0[127:64]);
        write_reg(REG_START_VALUE_LOW, y0[63:0]);
        cfg_wr_en <= 1'b0;
    endtask

    // Without a first block since reset, the chain starts from a zero accumulator.
    task automatic test_chain_from_reset();
        load_settings({$urandom, $urandom, $urandom, $urandom},
                      {$urandom, $urandom, $urandom, $urandom});
        send_block(rand64(), rand64(), 1'b0, 1'b0);
        send_block(rand64(), rand64(), 1'b0, 1'b1);
        wait_idle();
    endtask

    // Extreme data and settings, single-beat chains and non-final beats.
    task automatic test_field_extremes();
        load_settings(FIELD_ONE, '0);
        send_block({64{1'b1}}, {64{1'b1}}, 1'b1, 1'b1);
        send_block(64'd0, 64'd0, 1'b1, 1'b0);
        send_block({64{1'b1}}, 64'd0, 1'b0, 1'b1);
        send_block(64'd0, {64{1'b1}}, 1'b0, 1'b1);
        wait_idle();
        load_settings(ALL_ONES, ALL_ONES);
        send_block(64'd0, 64'd0, 1'b1, 1'b1);
        send_block({32{2'b10}}, {32{2'b01}}, 1'b1, 1'b0);
        send_block({32{2'b01}}, {32{2'b10}}, 1'b0, 1'b0);
        send_block(64'd1, 64'h8000_0000_0000_0000, 1'b0, 1'b1);
        send_block({64{1'b1}}, {64{1'b1}}, 1'b1, 1'b1);
        wait_idle();
    endtask

    // A zero key forces every product to zero.
    task automatic test_zero_key();
        load_settings('0, {$urandom, $urandom, $urandom, $urandom});
        send_block(rand64(), rand64(), 1'b1, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 1'b0, 1'b1);
        wait_idle();
    endtask

    // New settings between beats of one chain apply from the next beat on.
    task automatic test_rekey_mid_chain();
        load_settings({$urandom, $urandom, $urandom, $urandom},
                      {$urandom, $urandom, $urandom, $urandom});
        send_block(rand64(), rand64(), 1'b1, 1'b0);
        wait_idle();
        load_settings({$urandom, $urandom, $urandom, $urandom},
                      {$urandom, $urandom, $urandom, $urandom});
        send_block(rand64(), rand64(), 1'b0, 1'b0);
        send_block(rand64(), rand64(), 1'b0, 1'b1);
        wait_idle();
    endtask

    // Mostly well-formed chains with random content, some stray beats.
    task automatic test_random_stream(input int beats, input int idle_pct,
                                      input int stall_pct);
        int sent;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < beats)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_block(rand64(), rand64(), k == 0, k == len - 1);
                sent += len;
            end
            else
            begin
                send_block(rand64(), rand64(), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
                sent++;
            end
        end
        wait_idle();
    endtask

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("FAIL ghash_accumulator_unit");
        $finish;
    end

    initial
    begin
        blocks_if.valid       <= 1'b0;
        blocks_if.block_high  <= '0;
        blocks_if.block_low   <= '0;
        blocks_if.first_block <= 1'b0;
        blocks_if.last_block  <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= REG_HASH_KEY_HIGH;
        cfg_data              <= '0;
        hash_key       = '0;
        start_value    = '0;
        running_y      = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_chain_from_reset();
        test_field_extremes();
        test_zero_key();
        test_rekey_mid_chain();

        load_settings({$urandom, $urandom, $urandom, $urandom},
                      {$urandom, $urandom, $urandom, $urandom});
        test_random_stream(400, 0, 0);
        load_settings(ALL_ONES, '0);
        test_random_stream(300, 75, 0);
        load_settings({$urandom, $urandom, $urandom, $urandom}, ALL_ONES);
        test_random_stream(300, 0, 75);
        load_settings({$urandom, $urandom, $urandom, $urandom},
                      {$urandom, $urandom, $urandom, $urandom});
        test_random_stream(350, 6, 6);

        if (fail_count == 0)
            $display("PASS ghash_accumulator_unit");
        else
            $display("FAIL ghash_accumulator_unit");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ghash_pkg.sv
hw/rtl/ghash_in_if.sv
hw/rtl/ghash_out_if.sv
hw/rtl/ghash_datapath.sv
hw/rtl/ghash_controller.sv
hw/rtl/ghash_accumulator_unit.sv
verif/tb.sv
